// ===== rtl/odd_only_segmented_prime_sieve_unit_assert.svh =====
// Assertion macros used by the sieve unit.
`ifndef ODD_ONLY_SEGMENTED_PRIME_SIEVE_UNIT_ASSERT_SVH
`define ODD_ONLY_SEGMENTED_PRIME_SIEVE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define OSPS_ASSERT_IMP(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("sieve assertion failed");
// next-cycle implication
`define OSPS_ASSERT_NXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("sieve assertion failed");
`else
`define OSPS_ASSERT_IMP(lbl, ck, rs, a, b)
`define OSPS_ASSERT_NXT(lbl, ck, rs, a, b)
`endif
`endif

// ===== rtl/osps_pkg.sv =====
`timescale 1ns / 1ps
package osps_pkg;

  typedef struct packed {
    logic [31:0] range_low;
    logic [31:0] range_high;
  } osps_req_t;

  typedef struct packed {
    logic [16:0] prime_count;
    logic        range_error;
  } osps_rsp_t;

  localparam int unsigned FIRST_ODD = 3;
  localparam int unsigned PRIME_TWO = 2;

endpackage

// ===== rtl/odd_only_segmented_prime_sieve_unit.sv =====
`timescale 1ns / 1ps
`include "odd_only_segmented_prime_sieve_unit_assert.svh"
// Odd-only segmented prime sieve.
// Request channel (req_valid / req_stall / req): one item carries a closed
// range [range_low, range_high]; it is taken when req_valid is high and
// req_stall low. req_stall stays high from acceptance until the result has
// been loaded into the output register.
// Response channel (rsp_valid / rsp_stall / rsp): one item per request with
// prime_count and range_error; an error item carries a count of zero.
// Steps: the root comes out of a chain of (VALUE_BITS+1)/2 digit cells,
// then the small sieve clears and marks its store over the n odd numbers
// up to the root; the s segment entries are cleared; each small prime's
// first multiple in the segment comes from a restoring remainder and its
// multiples there are marked; last the s entries are read and counted.
// Each store has one write and one registered read port.
// A stalled response holds in the output register; the next request is
// still taken meanwhile and its result waits until the register frees.
// Reset (rst, synchronous) returns to idle and drops any pending result;
// the stores are not cleared, each request clears what it reads.
module odd_only_segmented_prime_sieve_unit #(
  parameter int SEGMENT_ODDS = 65536,
  parameter int SMALL_ODDS   = 32768,
  parameter int VALUE_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  osps_pkg::osps_req_t   req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output osps_pkg::osps_rsp_t   rsp
);
  import osps_pkg::*;

  localparam int VB  = VALUE_BITS;
  localparam int RW  = (VB + 1) / 2;
  localparam int PW  = RW + 1;
  localparam int FW  = 2 * PW;
  localparam int MW  = FW + 1;
  localparam int SIW = $clog2(SMALL_ODDS);
  localparam int GW  = $clog2(SEGMENT_ODDS);

  typedef enum logic [4:0] {
    S_IDLE, S_ROOT, S_CHECK, S_SCLR, S_SRD, S_SCHK, S_SPP, S_SMARK,
    S_GCLR, S_GRD, S_GCHK, S_GPP, S_GMST, S_GMWT, S_GODD, S_GK, S_GMARK,
    S_CRD, S_CUSE, S_DONE
  } state_t;

  state_t state;

  // request fields brought to the working width
  logic [VB+31:0] lo_w, hi_w;
  logic [VB-1:0]  lo_in, hi_in, start_in;

  logic [VB-1:0]   lo, hi, start;
  logic [RW-1:0]   root;
  logic [SIW:0]    small_n, sidx;
  logic [GW:0]     size, gidx;
  logic [FW-1:0]   pp, kk;
  logic [FW-1:0]   from;
  logic [MW-1:0]   m, gk;
  logic [16:0]     cnt;
  logic            two_in, err;

  // square-root cell chain
  logic            ch_vld  [0:RW];
  logic [RW+1:0]   ch_rem  [0:RW];
  logic [RW-1:0]   ch_root [0:RW];
  logic [2*RW-1:0] ch_data [0:RW];

  // stores
  logic small_mem [0:SMALL_ODDS-1];
  logic seg_mem   [0:SEGMENT_ODDS-1];
  logic small_rdata, seg_rdata;
  logic small_we, small_wd, seg_we, seg_wd;
  logic [SIW-1:0] small_wa;
  logic [GW-1:0]  seg_wa;

  logic [PW-1:0]  p_c;
  logic [FW-1:0]  pp_c;
  logic [VB:0]    size_c;
  logic [RW-1:0]  small_n_c;
  logic           mod_go, mod_done;
  logic [PW-1:0]  mod_rem;
  logic           accept;

  assign lo_w     = (VB + 32)'(req.range_low);
  assign hi_w     = (VB + 32)'(req.range_high);
  assign lo_in    = lo_w[VB-1:0];
  assign hi_in    = hi_w[VB-1:0];
  assign start_in = ((lo_in | VB'(1)) < VB'(FIRST_ODD)) ? VB'(FIRST_ODD) : (lo_in | VB'(1));

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  // odd candidate p = 2*i+3 and its square
  assign p_c  = PW'({sidx, 1'b1}) + PW'(PRIME_TWO);
  assign pp_c = p_c * p_c;

  assign size_c    = (start > hi) ? '0
                   : ((VB + 1)'(hi - start) >> 1) + (VB + 1)'(1);
  assign small_n_c = (root >= RW'(FIRST_ODD)) ? ((root - RW'(1)) >> 1) : '0;

  assign ch_vld[0]  = accept;
  assign ch_rem[0]  = '0;
  assign ch_root[0] = '0;
  assign ch_data[0] = (2 * RW)'(hi_in);

  for (genvar c = 0; c < RW; c++) begin : g_root
    osps_sqrt_cell #(.RW(RW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_vld  (ch_vld[c]),
      .up_rem  (ch_rem[c]),
      .up_root (ch_root[c]),
      .up_data (ch_data[c]),
      .dn_vld  (ch_vld[c+1]),
      .dn_rem  (ch_rem[c+1]),
      .dn_root (ch_root[c+1]),
      .dn_data (ch_data[c+1])
    );
  end

  assign mod_go = (state == S_GMST);

  osps_mod_unit #(.NW(FW), .DW(PW)) u_mod (
    .clk  (clk),
    .rst  (rst),
    .go   (mod_go),
    .num  (from),
    .den  (p_c),
    .done (mod_done),
    .rem  (mod_rem)
  );

  // store write ports: clear sweeps write zero, mark passes write one
  always_comb begin
    small_we = 1'b0;
    small_wd = 1'b0;
    small_wa = sidx[SIW-1:0];
    seg_we   = 1'b0;
    seg_wd   = 1'b0;
    seg_wa   = gidx[GW-1:0];
    unique case (state)
      S_SCLR: begin
        small_we = 1'b1;
      end
      S_SMARK: begin
        small_we = (64'(kk) < 64'(small_n));
        small_wd = 1'b1;
        small_wa = kk[SIW-1:0];
      end
      S_GCLR: begin
        // an empty odd part clears nothing
        seg_we = (gidx < size);
      end
      S_GMARK: begin
        seg_we = (64'(gk) < 64'(size));
        seg_wd = 1'b1;
        seg_wa = gk[GW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (small_we) begin
      small_mem[small_wa] <= small_wd;
    end
    small_rdata <= small_mem[sidx[SIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    seg_rdata <= seg_mem[gidx[GW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // drop a taken item unless a new one is loaded in its place
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lo    <= lo_in;
            hi    <= hi_in;
            start <= start_in;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          // wait for the root to leave the end of the cell chain
          if (ch_vld[RW]) begin
            root  <= ch_root[RW];
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          two_in <= (lo <= VB'(PRIME_TWO)) && (hi >= VB'(PRIME_TWO));
          cnt    <= '0;
          sidx   <= '0;
          gidx   <= '0;
          if ((hi < lo) || (64'(size_c) > 64'(SEGMENT_ODDS))
              || (64'(small_n_c) > 64'(SMALL_ODDS))) begin
            err   <= 1'b1;
            state <= S_DONE;
          end else begin
            err     <= 1'b0;
            size    <= (GW + 1)'(size_c);
            small_n <= (SIW + 1)'(small_n_c);
            state   <= (small_n_c == '0) ? S_GCLR : S_SCLR;
          end
        end
        S_SCLR: begin
          if (sidx + (SIW + 1)'(1) >= small_n) begin
            sidx  <= '0;
            state <= S_SRD;
          end else begin
            sidx <= sidx + (SIW + 1)'(1);
          end
        end
        S_SRD: begin
          state <= S_SCHK;
        end
        S_SCHK: begin
          pp    <= pp_c;
          state <= S_SPP;
        end
        S_SPP: begin
          if (!small_rdata && (pp <= FW'(root))) begin
            kk    <= (pp - FW'(FIRST_ODD)) >> 1;
            state <= S_SMARK;
          end else if (sidx + (SIW + 1)'(1) >= small_n) begin
            sidx  <= '0;
            state <= S_GCLR;
          end else begin
            sidx  <= sidx + (SIW + 1)'(1);
            state <= S_SRD;
          end
        end
        S_SMARK: begin
          if (64'(kk) >= 64'(small_n)) begin
            if (sidx + (SIW + 1)'(1) >= small_n) begin
              sidx  <= '0;
              state <= S_GCLR;
            end else begin
              sidx  <= sidx + (SIW + 1)'(1);
              state <= S_SRD;
            end
          end else begin
            kk <= kk + FW'(p_c);
          end
        end
        S_GCLR: begin
          if (size == '0) begin
            state <= S_DONE;
          end else if (gidx + (GW + 1)'(1) >= size) begin
            gidx  <= '0;
            state <= (small_n == '0) ? S_CRD : S_GRD;
          end else begin
            gidx <= gidx + (GW + 1)'(1);
          end
        end
        S_GRD: begin
          state <= S_GCHK;
        end
        S_GCHK: begin
          if (small_rdata) begin
            // composite: advance to the next odd candidate
            if (sidx + (SIW + 1)'(1) >= small_n) begin
              state <= S_CRD;
            end else begin
              sidx  <= sidx + (SIW + 1)'(1);
              state <= S_GRD;
            end
          end else begin
            pp    <= pp_c;
            state <= S_GPP;
          end
        end
        S_GPP: begin
          from  <= (pp < FW'(start)) ? FW'(start) : pp;
          state <= S_GMST;
        end
        S_GMST: begin
          state <= S_GMWT;
        end
        S_GMWT: begin
          if (mod_done) begin
            m <= (mod_rem == '0) ? MW'(from)
               : MW'(from) + MW'(p_c) - MW'(mod_rem);
            state <= S_GODD;
          end
        end
        S_GODD: begin
          if (!m[0]) begin
            m <= m + MW'(p_c);
          end
          state <= S_GK;
        end
        S_GK: begin
          gk    <= (m - MW'(start)) >> 1;
          state <= S_GMARK;
        end
        S_GMARK: begin
          if (64'(gk) >= 64'(size)) begin
            if (sidx + (SIW + 1)'(1) >= small_n) begin
              state <= S_CRD;
            end else begin
              sidx  <= sidx + (SIW + 1)'(1);
              state <= S_GRD;
            end
          end else begin
            gk <= gk + MW'(p_c);
          end
        end
        S_CRD: begin
          state <= S_CUSE;
        end
        S_CUSE: begin
          if (!seg_rdata) begin
            cnt <= cnt + 17'd1;
          end
          if (gidx + (GW + 1)'(1) >= size) begin
            state <= S_DONE;
          end else begin
            gidx  <= gidx + (GW + 1)'(1);
            state <= S_CRD;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid         <= 1'b1;
            rsp.range_error   <= err;
            rsp.prime_count   <= err ? '0 : (cnt + (two_in ? 17'd1 : 17'd0));
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OSPS_ASSERT_IMP(a_err_zero, clk, rst, rsp_valid && rsp.range_error, rsp.prime_count == '0)
  `OSPS_ASSERT_NXT(a_busy_after_take, clk, rst, accept, req_stall)
  `OSPS_ASSERT_IMP(a_small_in_bounds, clk, rst, small_we, 64'(small_wa) < 64'(small_n))
  `OSPS_ASSERT_IMP(a_seg_in_bounds, clk, rst, seg_we, 64'(seg_wa) < 64'(size))

endmodule

// ===== rtl/osps_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One digit step of the square root: takes two bits of the radicand a cycle.
module osps_sqrt_cell #(
  parameter int RW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_vld,
  input  logic [RW+1:0]     up_rem,
  input  logic [RW-1:0]     up_root,
  input  logic [2*RW-1:0]   up_data,
  output logic              dn_vld,
  output logic [RW+1:0]     dn_rem,
  output logic [RW-1:0]     dn_root,
  output logic [2*RW-1:0]   dn_data
);
  logic [RW+1:0] cand;
  logic [RW+1:0] trial;
  logic          ge;

  assign cand  = {up_rem[RW-1:0], up_data[2*RW-1 -: 2]};
  assign trial = {up_root, 2'b01};
  assign ge    = (cand >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else begin
      dn_vld <= up_vld;
    end
    dn_rem  <= ge ? (cand - trial) : cand;
    dn_root <= {up_root[RW-2:0], ge};
    dn_data <= {up_data[2*RW-3:0], 2'b00};
  end
endmodule

// ===== rtl/osps_mod_unit.sv =====
`timescale 1ns / 1ps
// Restoring remainder, one dividend bit a cycle.
module osps_mod_unit #(
  parameter int NW = 36,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] numr;
  logic [DW-1:0] denr;
  logic [DW:0]   part;
  logic [DW:0]   t;
  logic          ge;

  assign t   = {part[DW-1:0], numr[NW-1]};
  assign ge  = (t >= {1'b0, denr});
  assign rem = part[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        numr <= num;
        denr <= den;
        part <= '0;
      end else if (busy) begin
        // shift in the next bit and subtract where it fits
        part <= ge ? (t - {1'b0, denr}) : t;
        numr <= {numr[NW-2:0], 1'b0};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
